// File: hw/rtl/flash_job_chunk_sequencer_macros.svh
// Assertion macros for the flash job chunk sequencer.
// No dependencies; the using module provides clk and rst_n.
`ifndef FLASH_JOB_CHUNK_SEQUENCER_MACROS_SVH
`define FLASH_JOB_CHUNK_SEQUENCER_MACROS_SVH
`define FJCS_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define FJCS_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/fjcs_pkg.sv
// Package for the flash job chunk sequencer: payload types and codes.
// No dependencies.
`timescale 1ns / 1ps
package fjcs_pkg;
    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  instance_id;
        logic [31:0] address;
        logic [31:0] length;
        logic        buffer_present;
        logic [1:0]  hw_status;
        logic        hw_accept;
    } fjcs_in_t;

    typedef struct packed {
        logic        ret_ok;
        logic [2:0]  error_code;
        logic [2:0]  job_result;
        logic        cmd_valid;
        logic [1:0]  cmd_op;
        logic [31:0] cmd_address;
        logic [24:0] cmd_length;
        logic        cancel;
    } fjcs_out_t;

    localparam logic [2:0] REQ_READ = 3'd0;
    localparam logic [2:0] REQ_WRITE = 3'd1;
    localparam logic [2:0] REQ_ERASE = 3'd2;
    localparam logic [2:0] REQ_BLANK = 3'd3;
    localparam logic [2:0] REQ_TICK = 3'd4;
    localparam logic [2:0] REQ_ECC = 3'd5;
    localparam logic [2:0] REQ_DEINIT = 3'd6;
    localparam logic [2:0] REQ_INIT = 3'd7;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_UNINIT = 3'd1;
    localparam logic [2:0] ERR_INST = 3'd2;
    localparam logic [2:0] ERR_PTR = 3'd3;
    localparam logic [2:0] ERR_ADDR = 3'd4;
    localparam logic [2:0] ERR_LEN = 3'd5;
    localparam logic [2:0] ERR_PEND = 3'd6;

    localparam logic [2:0] RES_OK = 3'd0;
    localparam logic [2:0] RES_PENDING = 3'd1;
    localparam logic [2:0] RES_FAILED = 3'd2;
    localparam logic [2:0] RES_INCONS = 3'd3;
    localparam logic [2:0] RES_ECC = 3'd4;

    localparam logic [2:0] ACT_IDLE = 3'd0;
    localparam logic [2:0] ACT_BLANK = 3'd4;

    localparam logic [1:0] HW_IDLE = 2'd0;
    localparam logic [1:0] HW_ERROR = 2'd2;

    localparam logic [2:0] CFG_START = 3'd0;
    localparam logic [2:0] CFG_SCOUNT = 3'd1;
    localparam logic [2:0] CFG_SSIZE = 3'd2;
    localparam logic [2:0] CFG_RGRAN = 3'd3;
    localparam logic [2:0] CFG_PAGE = 3'd4;
endpackage

// File: hw/rtl/flash_job_chunk_sequencer.sv
// Flash job chunk sequencer: request checks, job store and chunk issue.
// Depends on fjcs_pkg and flash_job_chunk_sequencer_macros.svh.
// Job requests (read/write/erase/blank) pass through S_BOUND and the shared restoring
// divider (two 33-bit remainders, one bit a cycle) before S_EXEC; other requests go to S_EXEC.
// Throughput: one item at a time, in_stall high until the result is taken.
// Reset: all instances idle with result OK, block uninitialized, registers at defaults.
`timescale 1ns / 1ps
`include "flash_job_chunk_sequencer_macros.svh"
module flash_job_chunk_sequencer #(
    parameter int INSTANCES = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  fjcs_pkg::fjcs_in_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output fjcs_pkg::fjcs_out_t out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import fjcs_pkg::*;

    localparam int IW = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;

    typedef enum logic [2:0] {S_IDLE, S_BOUND, S_DIV1, S_DIV2, S_EXEC, S_OUT} state_t;

    state_t      state_reg;
    fjcs_in_t    req_reg;
    fjcs_out_t   out_reg;
    logic [31:0] start_reg;
    logic [15:0] scount_reg;
    logic [24:0] ssize_reg;
    logic [16:0] rgran_reg;
    logic [16:0] page_reg;
    logic        init_reg;
    logic [2:0]  res_reg [INSTANCES];
    logic [2:0]  act_reg [INSTANCES];
    logic [31:0] caddr_reg [INSTANCES];
    logic [31:0] rem_reg [INSTANCES];
    logic [24:0] chunk_reg [INSTANCES];
    logic [40:0] end_reg;
    logic [2:0]  err_reg;
    logic [32:0] dvd_reg;
    logic [32:0] prem_reg;
    logic [5:0]  cnt_reg;
    logic [24:0] align_reg;

    logic        inst_ok;
    logic [IW-1:0] idx;
    logic [24:0] align_w;
    logic [32:0] trial;
    logic [33:0] sub_w;

    assign inst_ok = {28'd0, req_reg.instance_id} < 32'(INSTANCES);
    assign idx = inst_ok ? req_reg.instance_id[IW-1:0] : '0;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data = out_reg;

    always_comb
    begin
        case (req_reg.req_type)
            REQ_WRITE: align_w = (page_reg == '0) ? 25'd1 : {8'd0, page_reg};
            REQ_ERASE: align_w = (ssize_reg == '0) ? 25'd1 : ssize_reg;
            default:   align_w = (rgran_reg == '0) ? 25'd1 : {8'd0, rgran_reg};
        endcase
    end

    assign trial = {prem_reg[31:0], dvd_reg[32]};
    assign sub_w = {1'b0, trial} - {9'd0, align_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            start_reg <= '0;
            scount_reg <= 16'd1;
            ssize_reg <= 25'd4096;
            rgran_reg <= 17'd1;
            page_reg <= 17'd4;
            init_reg <= 1'b0;
            for (int i = 0; i < INSTANCES; i++)
            begin
                res_reg[i] <= RES_OK;
                act_reg[i] <= ACT_IDLE;
                caddr_reg[i] <= '0;
                rem_reg[i] <= '0;
                chunk_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START:  start_reg <= cfg_data;
                    CFG_SCOUNT: scount_reg <= cfg_data[15:0];
                    CFG_SSIZE:  ssize_reg <= cfg_data[24:0];
                    CFG_RGRAN:  rgran_reg <= cfg_data[16:0];
                    CFG_PAGE:   page_reg <= cfg_data[16:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg <= in_data;
                        state_reg <= (in_data.req_type <= REQ_BLANK) ? S_BOUND : S_EXEC;
                    end
                end
                S_BOUND:
                begin
                    end_reg <= {9'd0, start_reg} + ({25'd0, scount_reg} * {16'd0, ssize_reg});
                    align_reg <= align_w;
                    dvd_reg <= {1'b0, req_reg.address - start_reg};
                    prem_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= S_DIV1;
                end
                S_DIV1, S_DIV2:
                begin
                    if (cnt_reg == 6'd32)
                    begin
                        cnt_reg <= '0;
                        if (state_reg == S_DIV1)
                        begin
                            err_reg <= (sub_w[33] ? trial : sub_w[32:0]) != '0 ? ERR_ADDR
                                                                                : ERR_NONE;
                            dvd_reg <= {1'b0, req_reg.length};
                            prem_reg <= '0;
                            state_reg <= S_DIV2;
                        end
                        else
                        begin
                            if ((sub_w[33] ? trial : sub_w[32:0]) != '0 && err_reg == ERR_NONE)
                                err_reg <= ERR_LEN;
                            state_reg <= S_EXEC;
                        end
                    end
                    else
                    begin
                        dvd_reg <= {dvd_reg[31:0], 1'b0};
                        prem_reg <= sub_w[33] ? trial : sub_w[32:0];
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_EXEC:
                begin
                    logic [2:0]  e;
                    logic [24:0] n;
                    logic        blank;
                    fjcs_out_t   o;
                    o = '0;
                    e = ERR_NONE;
                    blank = act_reg[idx] == ACT_BLANK;
                    if (req_reg.req_type <= REQ_BLANK)
                    begin
                        if (!init_reg) e = ERR_UNINIT;
                        else if (!inst_ok) e = ERR_INST;
                        else if (req_reg.req_type <= REQ_WRITE && !req_reg.buffer_present)
                            e = ERR_PTR;
                        else if (req_reg.length == '0) e = ERR_LEN;
                        else if ({9'd0, req_reg.address} < {9'd0, start_reg}
                                 || {9'd0, req_reg.address} >= end_reg) e = ERR_ADDR;
                        else if (err_reg == ERR_ADDR) e = ERR_ADDR;
                        else if ({9'd0, req_reg.address} + {9'd0, req_reg.length} > end_reg
                                 || err_reg == ERR_LEN) e = ERR_LEN;
                        else if (res_reg[idx] == RES_PENDING) e = ERR_PEND;
                        if (e == ERR_NONE)
                        begin
                            o.ret_ok = 1'b1;
                            res_reg[idx] <= RES_PENDING;
                            act_reg[idx] <= req_reg.req_type + 3'd1;
                            caddr_reg[idx] <= req_reg.address;
                            rem_reg[idx] <= req_reg.length;
                            chunk_reg[idx] <= (req_reg.req_type == REQ_BLANK)
                                ? ((ssize_reg == '0) ? 25'd1 : ssize_reg) : align_reg;
                        end
                        o.job_result = (e == ERR_NONE) ? RES_PENDING
                                     : (inst_ok ? res_reg[idx] : RES_OK);
                    end
                    else if (req_reg.req_type == REQ_TICK || req_reg.req_type == REQ_ECC)
                    begin
                        if (!init_reg) e = ERR_UNINIT;
                        else if (!inst_ok) e = ERR_INST;
                        o.job_result = inst_ok ? res_reg[idx] : RES_OK;
                        if (e == ERR_NONE)
                        begin
                            o.ret_ok = 1'b1;
                            if (req_reg.req_type == REQ_ECC)
                            begin
                                if (res_reg[idx] == RES_PENDING)
                                begin
                                    o.cancel = 1'b1;
                                    act_reg[idx] <= ACT_IDLE;
                                end
                                res_reg[idx] <= RES_ECC;
                                o.job_result = RES_ECC;
                            end
                            else if (res_reg[idx] == RES_PENDING)
                            begin
                                if (req_reg.hw_status == HW_IDLE)
                                begin
                                    if (rem_reg[idx] == '0)
                                    begin
                                        res_reg[idx] <= RES_OK;
                                        act_reg[idx] <= ACT_IDLE;
                                        o.job_result = RES_OK;
                                    end
                                    else
                                    begin
                                        n = (rem_reg[idx] < {7'd0, chunk_reg[idx]})
                                            ? rem_reg[idx][24:0] : chunk_reg[idx];
                                        o.cmd_valid = 1'b1;
                                        o.cmd_op = 2'(act_reg[idx] - 3'd1);
                                        o.cmd_address = caddr_reg[idx];
                                        o.cmd_length = n;
                                        if (req_reg.hw_accept && act_reg[idx] != ACT_IDLE)
                                        begin
                                            caddr_reg[idx] <= caddr_reg[idx] + {7'd0, n};
                                            rem_reg[idx] <= rem_reg[idx] - {7'd0, n};
                                        end
                                        else
                                        begin
                                            res_reg[idx] <= blank ? RES_INCONS : RES_FAILED;
                                            act_reg[idx] <= ACT_IDLE;
                                            o.job_result = blank ? RES_INCONS : RES_FAILED;
                                        end
                                    end
                                end
                                else if (req_reg.hw_status == HW_ERROR)
                                begin
                                    res_reg[idx] <= blank ? RES_INCONS : RES_FAILED;
                                    act_reg[idx] <= ACT_IDLE;
                                    o.job_result = blank ? RES_INCONS : RES_FAILED;
                                end
                            end
                        end
                    end
                    else if (req_reg.req_type == REQ_DEINIT)
                    begin
                        o.job_result = inst_ok ? res_reg[idx] : RES_OK;
                        if (!init_reg) e = ERR_UNINIT;
                        else
                        begin
                            o.ret_ok = 1'b1;
                            init_reg <= 1'b0;
                            for (int i = 0; i < INSTANCES; i++)
                            begin
                                if (res_reg[i] == RES_PENDING)
                                begin
                                    o.cancel = 1'b1;
                                    res_reg[i] <= RES_FAILED;
                                    act_reg[i] <= ACT_IDLE;
                                end
                            end
                            if (inst_ok && res_reg[idx] == RES_PENDING)
                                o.job_result = RES_FAILED;
                        end
                    end
                    else
                    begin
                        o.ret_ok = 1'b1;
                        init_reg <= 1'b1;
                        for (int i = 0; i < INSTANCES; i++)
                        begin
                            res_reg[i] <= RES_OK;
                            act_reg[i] <= ACT_IDLE;
                        end
                        o.job_result = RES_OK;
                    end
                    o.error_code = e;
                    out_reg <= o;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `FJCS_ASSERT_IMP(a_cmd_ok, out_valid && out_data.cmd_valid, out_data.ret_ok)
    `FJCS_ASSERT_IMP(a_err_ok, out_valid && out_data.ret_ok, out_data.error_code == ERR_NONE)
    `FJCS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data))
endmodule
